[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rate limiter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define WBRL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define WBRL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WBRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/wbrl_pkg.sv]
// ----------------------------------------------------------------------------
// wbrl_pkg
// Types and fixed constants shared by the windowed byte rate limiter.
// ----------------------------------------------------------------------------
package wbrl_pkg;

   localparam int COUNT_W     = 31;
   localparam int GRANT_W     = 32;
   localparam int AVAIL_W     = 34;   // bit 33 marks "budget is plenty"
   localparam int QUOT_W      = 22;   // rate / 1000 for a 31-bit rate
   localparam int FRAC_W      = 10;   // rate % 1000, and the sub-byte carry
   localparam int MS_PER_SEC  = 1000;
   localparam int RECIP_SHIFT = 41;

   // ceil(2^41 / 1000): exact quotient by 1000 for any 31-bit rate
   localparam logic [31:0] RECIP_K = 32'd2199023256;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      FUNC_TICK      = 2'd0,
      FUNC_REQUEST   = 2'd1,
      FUNC_GIVE_BACK = 2'd2
   } func_type;

   typedef struct packed {
      logic              zero;
      logic [QUOT_W-1:0] quot;
      logic [FRAC_W-1:0] frac;
   } rate_cfg_type;

   typedef struct packed {
      logic               advance;
      logic               restart;
      logic               take;
      logic               give_back;
      logic [COUNT_W-1:0] amount;
   } window_ctl_type;

   typedef struct packed {
      logic               stale;
      logic [COUNT_W-1:0] budget;
   } window_sts_type;

endpackage

[rtl/wbrl_cfg.sv]
// ----------------------------------------------------------------------------
// wbrl_cfg
// Rate register, split into bytes per millisecond and a remainder in
// thousandths of a byte per millisecond.
// ----------------------------------------------------------------------------
module wbrl_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [wbrl_pkg::COUNT_W-1:0]        csr_wdata,
   output wbrl_pkg::rate_cfg_type              rate_cfg
);

   localparam int PROD_W = wbrl_pkg::COUNT_W + 32;

   logic [PROD_W-1:0]                recip_prod;
   logic [wbrl_pkg::COUNT_W-1:0]     whole;
   logic [wbrl_pkg::COUNT_W-1:0]     rate_ff, rate_in;
   logic [wbrl_pkg::QUOT_W-1:0]      quot_ff, quot_in;
   logic [wbrl_pkg::FRAC_W-1:0]      frac_ff, frac_in;
   logic                             zero_ff, zero_in;

   // quotient by 1000 through the reciprocal, straight off the write port
   assign recip_prod = {32'd0, csr_wdata} * {{wbrl_pkg::COUNT_W{1'b0}}, wbrl_pkg::RECIP_K};

   // remainder from the registered rate and quotient, registered in turn
   assign whole   = wbrl_pkg::COUNT_W'(quot_ff) * wbrl_pkg::COUNT_W'(wbrl_pkg::MS_PER_SEC);
   assign frac_in = wbrl_pkg::FRAC_W'(rate_ff - whole);

   assign rate_in = csr_we ? csr_wdata : rate_ff;
   assign quot_in = csr_we ? recip_prod[wbrl_pkg::RECIP_SHIFT +: wbrl_pkg::QUOT_W] : quot_ff;
   assign zero_in = csr_we ? (csr_wdata == '0) : zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= '0;
         quot_ff <= '0;
         frac_ff <= '0;
         zero_ff <= 1'b1;
      end else begin
         rate_ff <= rate_in;
         quot_ff <= quot_in;
         frac_ff <= frac_in;
         zero_ff <= zero_in;
      end
   end

   assign rate_cfg.zero = zero_ff;
   assign rate_cfg.quot = quot_ff;
   assign rate_cfg.frac = frac_ff;

endmodule

[rtl/wbrl_window.sv]
// ----------------------------------------------------------------------------
// wbrl_window
// Window counters: elapsed milliseconds, bytes earned, bytes granted and
// idle time. Bytes earned are accumulated per tick instead of multiplied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wbrl_window #(
   parameter int IDLE_RESET_MS = 100,
   parameter int ELAPSED_BITS  = 41
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  wbrl_pkg::rate_cfg_type      rate_cfg,
   input  logic                        tick_view,
   input  wbrl_pkg::window_ctl_type    win_ctl,
   output wbrl_pkg::window_sts_type    win_sts
);

   localparam int IDLE_W = $clog2(IDLE_RESET_MS + 2);
   localparam logic [IDLE_W-1:0] IDLE_SAT   = IDLE_W'(IDLE_RESET_MS + 1);
   localparam logic [IDLE_W-1:0] IDLE_LIMIT = IDLE_W'(IDLE_RESET_MS);
   localparam int AW = wbrl_pkg::AVAIL_W;
   localparam int GW = wbrl_pkg::GRANT_W;
   localparam int FW = wbrl_pkg::FRAC_W;

   logic [ELAPSED_BITS-1:0] elapsed_ff, elapsed_in;
   logic [AW-1:0]           avail_ff, avail_in;
   logic [FW-1:0]           frac_ff, frac_in;
   logic [IDLE_W-1:0]       idle_ff, idle_in;
   logic [GW-1:0]           granted_ff, granted_in;

   logic                    elapsed_max;
   logic [FW:0]             frac_sum;
   logic                    carry;
   logic [FW-1:0]           frac_adv;
   logic [AW-1:0]           avail_step, avail_adv, avail_view;
   logic [AW:0]             diff;
   logic [GW:0]             grant_sum;
   logic [GW-1:0]           give_amt;

   assign elapsed_max = &elapsed_ff;

   // one millisecond earns quot bytes plus frac thousandths
   assign frac_sum   = {1'b0, frac_ff} + {1'b0, rate_cfg.frac};
   assign carry      = frac_sum >= (FW + 1)'(wbrl_pkg::MS_PER_SEC);
   assign frac_adv   = carry ? FW'(frac_sum - (FW + 1)'(wbrl_pkg::MS_PER_SEC)) : FW'(frac_sum);
   assign avail_step = avail_ff + AW'(rate_cfg.quot) + AW'(carry);
   // freeze once elapsed saturates or the top bit says the budget is plenty
   assign avail_adv  = (elapsed_max || avail_ff[AW-1]) ? avail_ff : avail_step;
   assign avail_view = tick_view ? avail_adv : avail_ff;

   assign diff = {1'b0, avail_view} - {{(AW + 1 - GW){1'b0}}, granted_ff};

   always_comb begin
      if (avail_view[AW-1]) begin
         win_sts.budget = wbrl_pkg::COUNT_MAX;
      end else if (diff[AW] || diff == '0) begin
         win_sts.budget = '0;
      end else if (diff > (AW + 1)'(wbrl_pkg::COUNT_MAX)) begin
         win_sts.budget = wbrl_pkg::COUNT_MAX;
      end else begin
         win_sts.budget = diff[wbrl_pkg::COUNT_W-1:0];
      end
   end

   assign win_sts.stale = (granted_ff > {1'b0, wbrl_pkg::COUNT_MAX}) || (idle_ff > IDLE_LIMIT);

   assign grant_sum = {1'b0, granted_ff} + (GW + 1)'(win_ctl.amount);
   assign give_amt  = GW'(win_ctl.amount);

   always_comb begin
      elapsed_in = elapsed_ff;
      avail_in   = avail_ff;
      frac_in    = frac_ff;
      idle_in    = idle_ff;
      granted_in = granted_ff;
      if (csr_we || win_ctl.restart) begin
         elapsed_in = '0;
         avail_in   = '0;
         frac_in    = '0;
         granted_in = '0;
         idle_in    = IDLE_SAT;
      end else begin
         if (win_ctl.advance) begin
            if (!elapsed_max) begin
               elapsed_in = elapsed_ff + ELAPSED_BITS'(1);
               frac_in    = frac_adv;
            end
            avail_in = avail_adv;
            if (idle_ff != IDLE_SAT) begin
               idle_in = idle_ff + IDLE_W'(1);
            end
         end
         if (win_ctl.take) begin
            idle_in    = '0;
            granted_in = grant_sum[GW] ? '1 : grant_sum[GW-1:0];
         end else if (win_ctl.give_back) begin
            granted_in = (granted_ff > give_amt) ? (granted_ff - give_amt) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         avail_ff   <= '0;
         frac_ff    <= '0;
         idle_ff    <= IDLE_SAT;
         granted_ff <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
         avail_ff   <= avail_in;
         frac_ff    <= frac_in;
         idle_ff    <= idle_in;
         granted_ff <= granted_in;
      end
   end

   `WBRL_ASSERT(a_frac_range, clock, reset, frac_ff < FW'(wbrl_pkg::MS_PER_SEC), "byte fraction out of range")
   `WBRL_ASSERT(a_idle_range, clock, reset, idle_ff <= IDLE_SAT, "idle counter past saturation")
   `WBRL_ASSERT_NEXT(a_csr_restart, clock, reset, csr_we, granted_ff == '0 && avail_ff == '0, "rate write did not restart window")

endmodule

[rtl/wbrl_core.sv]
// ----------------------------------------------------------------------------
// wbrl_core
// Input register, grant decision, pending request and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wbrl_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_func,
   input  logic [wbrl_pkg::COUNT_W-1:0]    req_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [wbrl_pkg::COUNT_W-1:0]    rsp_granted_bytes,
   output logic                            rsp_refused,
   input  wbrl_pkg::rate_cfg_type          rate_cfg,
   input  wbrl_pkg::window_sts_type        win_sts,
   output logic                            tick_view,
   output wbrl_pkg::window_ctl_type        win_ctl
);

   localparam int CW = wbrl_pkg::COUNT_W;

   logic          in_vld_ff, in_vld_in;
   logic [1:0]    in_func_ff, in_func_in;
   logic [CW-1:0] in_count_ff, in_count_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] pend_count_ff, pend_count_in;
   logic          rsp_vld_ff, rsp_vld_in;
   logic [CW-1:0] rsp_granted_ff, rsp_granted_in;
   logic          rsp_refused_ff, rsp_refused_in;

   logic          is_tick, is_give;
   logic [CW-1:0] want, share;
   logic          has_result, res_refused, take_c, restart_c, pend_set, pend_clr;
   logic [CW-1:0] res_granted;
   logic          fire, load_rsp;

   assign is_tick   = in_func_ff == wbrl_pkg::FUNC_TICK;
   assign is_give   = in_func_ff == wbrl_pkg::FUNC_GIVE_BACK;
   assign tick_view = is_tick;

   assign want  = is_tick ? pend_count_ff : in_count_ff;
   assign share = (want < win_sts.budget) ? want : win_sts.budget;

   always_comb begin
      has_result  = 1'b0;
      res_granted = '0;
      res_refused = 1'b0;
      take_c      = 1'b0;
      restart_c   = 1'b0;
      pend_set    = 1'b0;
      pend_clr    = 1'b0;
      case (in_func_ff)
         wbrl_pkg::FUNC_TICK: begin
            if (pend_ff) begin
               if (rate_cfg.zero) begin
                  has_result  = 1'b1;
                  res_granted = pend_count_ff;
                  pend_clr    = 1'b1;
               end else if (win_sts.budget != '0) begin
                  has_result  = 1'b1;
                  res_granted = share;
                  take_c      = 1'b1;
                  pend_clr    = 1'b1;
               end
            end
         end
         wbrl_pkg::FUNC_REQUEST: begin
            if (rate_cfg.zero) begin
               has_result  = 1'b1;
               res_granted = in_count_ff;
            end else if (pend_ff) begin
               has_result  = 1'b1;
               res_refused = 1'b1;
            end else if (win_sts.stale) begin
               // a fresh window has earned nothing yet: park the request
               restart_c = 1'b1;
               pend_set  = 1'b1;
            end else if (win_sts.budget != '0) begin
               has_result  = 1'b1;
               res_granted = share;
               take_c      = 1'b1;
            end else begin
               pend_set = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // an item with no result never waits on the output side
   assign fire     = in_vld_ff && (!has_result || !rsp_vld_ff || rsp_ready);
   assign load_rsp = fire && has_result;

   assign win_ctl.advance   = fire && is_tick;
   assign win_ctl.restart   = fire && restart_c;
   assign win_ctl.take      = fire && take_c;
   assign win_ctl.give_back = fire && is_give;
   assign win_ctl.amount    = is_give ? in_count_ff : share;

   assign req_ready = !csr_we && (!in_vld_ff || fire);

   assign in_vld_in   = (req_valid && req_ready) || (in_vld_ff && !fire);
   assign in_func_in  = (req_valid && req_ready) ? req_func : in_func_ff;
   assign in_count_in = (req_valid && req_ready) ? req_count : in_count_ff;

   assign pend_in       = (fire && pend_set) ? 1'b1 : ((fire && pend_clr) ? 1'b0 : pend_ff);
   assign pend_count_in = (fire && pend_set) ? in_count_ff : pend_count_ff;

   assign rsp_vld_in     = load_rsp || (rsp_vld_ff && !rsp_ready);
   assign rsp_granted_in = load_rsp ? res_granted : rsp_granted_ff;
   assign rsp_refused_in = load_rsp ? res_refused : rsp_refused_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         pend_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         pend_ff    <= pend_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_func_ff     <= in_func_in;
      in_count_ff    <= in_count_in;
      pend_count_ff  <= pend_count_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_refused_ff <= rsp_refused_in;
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_granted_bytes = rsp_granted_ff;
   assign rsp_refused       = rsp_refused_ff;

   `WBRL_ASSERT_NEXT(a_in_hold, clock, reset, in_vld_ff && !fire, in_vld_ff && $stable(in_count_ff), "stalled item lost")
   `WBRL_ASSERT_NEXT(a_pend_hold, clock, reset, pend_ff && !(fire && is_tick), pend_ff, "pending request dropped without a tick")
   `WBRL_ASSERT_IMPL(a_refused_zero, clock, reset, rsp_vld_ff && rsp_refused_ff, rsp_granted_ff == '0, "refused item carries a grant")

endmodule

[rtl/windowed_byte_rate_limiter.sv]
// ----------------------------------------------------------------------------
// windowed_byte_rate_limiter
// Grants bytes against a rate in bytes per second over a millisecond window.
// req_* carries ticks (one per millisecond), byte requests and give-backs;
// rsp_* returns one item per answered request: the bytes granted, or a refusal
// when another request is already parked. Ticks and give-backs return nothing,
// except a tick that releases a parked request.
// csr_we/csr_wdata write the rate; a write restarts the window and a zero rate
// passes every request through in full.
// An accepted item waits in the input register; its result goes to the result
// register, which drives rsp_valid. Throughput: one item per cycle unless
// a csr write or a held result stalls it, set by the single decision stage
// (earned budget add, subtract against granted, min against the count).
// req_ready drops during a csr write; the rate quotient settles at that edge
// and the remainder at the following one, in time for the next item.
// Reset: rate zero, window empty, idle time saturated, nothing parked.
// When rsp_ready is low, the result register holds its item; items that
// produce no result keep flowing, and a result-producing item waits in the
// input register, stalling req_ready.
// ----------------------------------------------------------------------------
module windowed_byte_rate_limiter #(
   parameter int IDLE_RESET_MS = 100,
   parameter int ELAPSED_BITS  = 41
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_func,
   input  logic [wbrl_pkg::COUNT_W-1:0]    req_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [wbrl_pkg::COUNT_W-1:0]    rsp_granted_bytes,
   output logic                            rsp_refused,
   input  logic                            csr_we,
   input  logic [wbrl_pkg::COUNT_W-1:0]    csr_wdata
);

   wbrl_pkg::rate_cfg_type    rate_cfg;
   wbrl_pkg::window_sts_type  win_sts;
   wbrl_pkg::window_ctl_type  win_ctl;
   logic                      tick_view;

   wbrl_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rate_cfg  (rate_cfg)
   );

   wbrl_window #(
      .IDLE_RESET_MS (IDLE_RESET_MS),
      .ELAPSED_BITS  (ELAPSED_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .rate_cfg  (rate_cfg),
      .tick_view (tick_view),
      .win_ctl   (win_ctl),
      .win_sts   (win_sts)
   );

   wbrl_core u_core (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_count         (req_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_granted_bytes (rsp_granted_bytes),
      .rsp_refused       (rsp_refused),
      .rate_cfg          (rate_cfg),
      .win_sts           (win_sts),
      .tick_view         (tick_view),
      .win_ctl           (win_ctl)
   );

endmodule
